>>> rtl/ccr_pkg.sv
// Shared types, widths and codes of the clipped circle rasterizer.
package ccr_pkg;

  localparam int COORD_BITS  = 10;
  localparam int COLOR_BITS  = 4;
  localparam int WIDTH_BITS  = 10;
  localparam int HEIGHT_BITS = 11;
  localparam int NUM_PIX     = 8;
  localparam int CNT_BITS    = $clog2(NUM_PIX + 1);

  // walk state and clamp arithmetic widths
  localparam int STEP_BITS = COORD_BITS + 2;
  localparam int ERR_BITS  = COORD_BITS + 6;
  localparam int SUM_BITS  = COORD_BITS + 4;

  localparam int PADDR_BITS = 3;
  localparam int PDATA_BITS = 32;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  localparam logic REG_IDX_WIDTH  = 1'b0;
  localparam logic REG_IDX_HEIGHT = 1'b1;

  localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = WIDTH_BITS'(512);
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(480);

  typedef struct packed {
    logic                  action;
    logic [COORD_BITS-1:0] center_x;
    logic [COORD_BITS-1:0] center_y;
    logic [COORD_BITS-1:0] radius;
    logic [COLOR_BITS-1:0] pen_color;
  } ccr_in_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  last_of_step;
    logic                  circle_done;
  } ccr_out_t;

  typedef ccr_out_t [NUM_PIX-1:0] ccr_pix_set_t;

  typedef struct packed {
    logic [WIDTH_BITS-1:0]  col_limit;
    logic [HEIGHT_BITS-1:0] row_count;
  } ccr_cfg_t;

  typedef struct packed {
    logic         load;
    ccr_pix_set_t pix;
  } ccr_load_t;

  typedef struct packed {
    logic                busy;
    logic [CNT_BITS-1:0] remain;
  } ccr_status_t;

endpackage

>>> rtl/ccr_regs.sv
// Canvas size configuration registers behind the APB-style port.
module ccr_regs import ccr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [PDATA_BITS-1:0] pwdata,
  output logic [PDATA_BITS-1:0] prdata,
  output logic                  pready,
  output ccr_cfg_t              cfg_o
);

  logic [WIDTH_BITS-1:0]  width_q, width_d;
  logic [HEIGHT_BITS-1:0] height_q, height_d;
  logic                   wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (wr_en) begin
      case (paddr[2])
        REG_IDX_WIDTH:  width_d  = pwdata[WIDTH_BITS-1:0];
        REG_IDX_HEIGHT: height_d = pwdata[HEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_IDX_WIDTH:  prdata = PDATA_BITS'(width_q);
      REG_IDX_HEIGHT: prdata = PDATA_BITS'(height_q);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  assign cfg_o.col_limit = width_q;
  assign cfg_o.row_count = height_q;

endmodule

>>> rtl/ccr_step.sv
// Circle walk state, eight clipped symmetric pixels per step, and err/x/y update.
module ccr_step import ccr_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  ccr_in_t   in_data_i,
  input  ccr_cfg_t  cfg_i,
  output ccr_load_t load_o,
  output logic      busy_o
);

  localparam logic signed [SUM_BITS-1:0]  CoordMask = SUM_BITS'((1 << COORD_BITS) - 1);
  localparam logic signed [ERR_BITS-1:0]  OneE      = ERR_BITS'(1);
  localparam logic signed [ERR_BITS-1:0]  TwoE      = ERR_BITS'(2);
  localparam logic signed [STEP_BITS-1:0] OneS      = STEP_BITS'(1);

  function automatic logic [COORD_BITS-1:0] clamp_col(
    input logic signed [SUM_BITS-1:0] v,
    input logic [WIDTH_BITS-1:0]      w
  );
    logic signed [SUM_BITS-1:0] ws;
    ws = $signed(SUM_BITS'(w));
    if (v < 0)       return '0;
    else if (v > ws) return COORD_BITS'(w);
    else             return COORD_BITS'(v);
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp_row(
    input logic signed [SUM_BITS-1:0] v,
    input logic [HEIGHT_BITS-1:0]     h
  );
    logic signed [SUM_BITS-1:0] hs;
    logic signed [SUM_BITS-1:0] lim;
    hs  = $signed(SUM_BITS'(h));
    lim = (h == '0) ? '0 : hs - SUM_BITS'(1);
    if (lim > CoordMask) lim = CoordMask;
    if (v < 0)                    return '0;
    else if (v >= hs || v > lim) return COORD_BITS'(lim);
    else                          return COORD_BITS'(v);
  endfunction

  logic [COORD_BITS-1:0]        ccol_q, ccol_d;
  logic [COORD_BITS-1:0]        crow_q, crow_d;
  logic [COLOR_BITS-1:0]        color_q, color_d;
  logic signed [STEP_BITS-1:0]  x_q, x_d;
  logic signed [STEP_BITS-1:0]  y_q, y_d;
  logic signed [ERR_BITS-1:0]   err_q, err_d;
  logic                         busy_q, busy_d;

  logic signed [SUM_BITS-1:0]   cxs, cys, xs, ys;
  logic [COORD_BITS-1:0]        col_px, col_mx, col_py, col_my;
  logic [COORD_BITS-1:0]        row_py, row_my, row_px, row_mx;
  logic signed [STEP_BITS-1:0]  x1, y1;
  logic signed [ERR_BITS-1:0]   e1, e2;
  logic signed [STEP_BITS:0]    xy_sum;
  logic                         step_go, done;

  assign cxs = $signed(SUM_BITS'(ccol_q));
  assign cys = $signed(SUM_BITS'(crow_q));
  assign xs  = SUM_BITS'(x_q);
  assign ys  = SUM_BITS'(y_q);

  assign col_px = clamp_col(cxs + xs, cfg_i.col_limit);
  assign col_mx = clamp_col(cxs - xs, cfg_i.col_limit);
  assign col_py = clamp_col(cxs + ys, cfg_i.col_limit);
  assign col_my = clamp_col(cxs - ys, cfg_i.col_limit);
  assign row_py = clamp_row(cys + ys, cfg_i.row_count);
  assign row_my = clamp_row(cys - ys, cfg_i.row_count);
  assign row_px = clamp_row(cys + xs, cfg_i.row_count);
  assign row_mx = clamp_row(cys - xs, cfg_i.row_count);

  // err update: y moves first; the x test checks the old err against x and the updated err against the updated y
  always_comb begin
    if (err_q <= ERR_BITS'(y_q)) begin
      y1 = y_q + OneS;
      e1 = err_q + (ERR_BITS'(y1) <<< 1) + OneE;
    end else begin
      y1 = y_q;
      e1 = err_q;
    end
    if (err_q > ERR_BITS'(x_q) || e1 > ERR_BITS'(y1)) begin
      x1 = x_q + OneS;
      e2 = e1 + (ERR_BITS'(x1) <<< 1) + OneE;
    end else begin
      x1 = x_q;
      e2 = e1;
    end
  end

  assign xy_sum  = (STEP_BITS+1)'(x1) + (STEP_BITS+1)'(y1);
  assign done    = (xy_sum > 0);
  assign step_go = accept_i & (in_data_i.action == ACT_STEP) & busy_q;

  always_comb begin
    load_o.load = step_go;
    for (int i = 0; i < NUM_PIX; i++) begin
      load_o.pix[i].pixel_color  = color_q;
      load_o.pix[i].last_of_step = 1'b0;
      load_o.pix[i].circle_done  = 1'b0;
    end
    load_o.pix[0].pixel_x = col_px; load_o.pix[0].pixel_y = row_py;
    load_o.pix[1].pixel_x = col_mx; load_o.pix[1].pixel_y = row_py;
    load_o.pix[2].pixel_x = col_px; load_o.pix[2].pixel_y = row_my;
    load_o.pix[3].pixel_x = col_mx; load_o.pix[3].pixel_y = row_my;
    load_o.pix[4].pixel_x = col_py; load_o.pix[4].pixel_y = row_px;
    load_o.pix[5].pixel_x = col_my; load_o.pix[5].pixel_y = row_px;
    load_o.pix[6].pixel_x = col_py; load_o.pix[6].pixel_y = row_mx;
    load_o.pix[7].pixel_x = col_my; load_o.pix[7].pixel_y = row_mx;
    load_o.pix[NUM_PIX-1].last_of_step = 1'b1;
    load_o.pix[NUM_PIX-1].circle_done  = done;
  end

  always_comb begin
    ccol_d  = ccol_q;
    crow_d  = crow_q;
    color_d = color_q;
    x_d     = x_q;
    y_d     = y_q;
    err_d   = err_q;
    busy_d  = busy_q;
    if (accept_i && in_data_i.action == ACT_START) begin
      ccol_d  = in_data_i.center_x;
      crow_d  = in_data_i.center_y;
      color_d = in_data_i.pen_color;
      x_d     = -$signed(STEP_BITS'(in_data_i.radius));
      y_d     = '0;
      err_d   = TwoE - ($signed(ERR_BITS'(in_data_i.radius)) <<< 1);
      busy_d  = 1'b1;
    end else if (step_go) begin
      x_d    = x1;
      y_d    = y1;
      err_d  = e2;
      busy_d = ~done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ccol_q  <= '0;
      crow_q  <= '0;
      color_q <= '0;
      x_q     <= '0;
      y_q     <= '0;
      err_q   <= '0;
      busy_q  <= 1'b0;
    end else begin
      ccol_q  <= ccol_d;
      crow_q  <= crow_d;
      color_q <= color_d;
      x_q     <= x_d;
      y_q     <= y_d;
      err_q   <= err_d;
      busy_q  <= busy_d;
    end
  end

  assign busy_o = busy_q;

endmodule

>>> rtl/ccr_emit.sv
// Eight-entry pixel result buffer, shifted out one pixel per accepted output transfer.
module ccr_emit import ccr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ccr_load_t           load_i,
  output logic                take_ok_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ccr_out_t            out_data_o,
  output logic [CNT_BITS-1:0] remain_o
);

  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  ccr_pix_set_t        buf_q, buf_d;
  logic                pop;

  assign out_valid_o = (cnt_q != '0);
  assign pop         = out_valid_o & out_ready_i;
  // a new step may load as the final pixel leaves
  assign take_ok_o   = (cnt_q == '0) || (cnt_q == CNT_BITS'(1) && out_ready_i);

  always_comb begin
    cnt_d = cnt_q;
    buf_d = buf_q;
    if (load_i.load) begin
      cnt_d = CNT_BITS'(NUM_PIX);
      buf_d = load_i.pix;
    end else if (pop) begin
      cnt_d = cnt_q - CNT_BITS'(1);
      for (int i = 0; i < NUM_PIX - 1; i++) begin
        buf_d[i] = buf_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  assign out_data_o = buf_q[0];
  assign remain_o   = cnt_q;

endmodule

>>> rtl/clipped_circle_rasterizer_core.sv
// Top level of the clipped circle outline rasterizer.
//
// Input channel (in_valid_i/in_ready_o, in_data_i): a start request latches
// centre, radius and colour and produces no pixels; a step request on a
// running circle produces eight clipped outline pixels, a step while idle
// produces nothing. Output channel (out_valid_o/out_ready_i, out_data_o)
// carries one pixel per cycle while out_ready_i is high; the eighth pixel of a
// step has last_of_step set and, when the walk has ended, circle_done.
// The first pixel of a step is valid the cycle after the request is taken.
// The eight-pixel buffer drains one pixel per cycle while out_ready_i is
// high; the next step is taken in the cycle its last pixel leaves. Start
// requests and idle steps load no pixels into the buffer.
// When the receiver stalls, the buffer holds its pixels and in_ready_o stays
// low; it is high only with the buffer empty or as the last pixel leaves.
// The APB-style port holds the column limit (0x0) and the row count (0x4);
// write them only while no pixels are pending.
// Reset: circle idle, buffer empty, width 512, height 480.
module clipped_circle_rasterizer_core import ccr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  ccr_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ccr_out_t              out_data_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [PDATA_BITS-1:0] pwdata,
  output logic [PDATA_BITS-1:0] prdata,
  output logic                  pready
);

  ccr_cfg_t    cfg;
  ccr_load_t   load;
  ccr_status_t status;
  logic        accept;

  assign accept = in_valid_i & in_ready_o;

  ccr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ccr_step u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_data_i (in_data_i),
    .cfg_i     (cfg),
    .load_o    (load),
    .busy_o    (status.busy)
  );

  ccr_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .take_ok_o   (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .remain_o    (status.remain)
  );

  // a running step's buffer never accepts a new request while stalled
  a_no_take_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while output stalled");

  // a step on a running circle fills the whole buffer
  a_step_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.action == ACT_STEP && status.busy
    |=> out_valid_o && status.remain == CNT_BITS'(NUM_PIX))
    else $error("step did not load eight pixels");

  // last_of_step marks exactly the final buffered pixel
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.last_of_step == (status.remain == CNT_BITS'(1)))
    else $error("last_of_step misplaced");

  a_done_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.circle_done |-> out_data_o.last_of_step && !status.busy)
    else $error("circle_done off the last pixel or while still busy");

endmodule
